// ----- rtl/dts_pkg.sv -----
// Shared types and constants for the DRAM transaction scheduler.
// No dependencies; used by dram_transaction_scheduler.
`default_nettype none
package dts_pkg;

    localparam int TOKEN_NEED = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    localparam logic [1:0] ACT_PUSH   = 2'd0;
    localparam logic [1:0] ACT_SCHED  = 2'd1;
    localparam logic [1:0] ACT_BANK   = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_FIRST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_MARK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_MARK   = 3'd4;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  channel;
        logic        is_write;
        logic [31:0] address;
        logic [5:0]  bank;
        logic [15:0] row;
        logic [15:0] seq_num;
        logic [7:0]  txn_tag;
        logic        row_open;
        logic [15:0] open_row;
        logic [3:0]  tokens;
    } t_in;

    typedef struct packed {
        logic        accepted;
        logic        write_hit;
        logic        issued;
        logic [7:0]  issued_tag;
        logic        issued_is_write;
        logic [31:0] issued_address;
        logic [5:0]  issued_bank;
        logic [15:0] issued_row;
    } t_out;

    // one queued transaction
    typedef struct packed {
        logic [31:0] address;
        logic        is_write;
        logic [5:0]  bank;
        logic [15:0] row;
        logic [7:0]  tag;
        logic [15:0] seq;
    } t_entry;

    // one bank's status
    typedef struct packed {
        logic        row_open;
        logic [15:0] open_row;
        logic [3:0]  tokens;
    } t_bank;

endpackage
`default_nettype wire

// ----- rtl/dts_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module dts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/dram_transaction_scheduler.sv -----
// Top level of the DRAM transaction scheduler: queue sequencer and bank table.
// Depends on dts_pkg and dts_ram.
//
// Usage: items arrive on i_data (valid/ready), one result per item leaves on
// o_data (valid/ready). Action push queues a transaction (and for a read
// reports a queued write to the same address), schedule removes and reports
// one transaction of a channel, bank status updates a bank's open row and
// tokens. Configuration is written through i_cfg_wr_en/i_cfg_index/i_cfg_data;
// the user must do so only while idle; the block itself does not enforce it.
// One item is worked on at a time; all queue entries sit in one RAM with registered
// read data. Bank status writes the bank table; push scans the entries of the hit
// queue; schedule checks each candidate's bank and tokens and scans its dependency
// entries, shifts the entries behind the removed one down one at a time, and in
// read-first mode tries the other queue when one yields nothing.
// The result sits in an output register; the next item is taken once that
// result has moved to the output register, so a stalled receiver leaves one
// result in the output register and one finished item waiting for it; input
// is then blocked.
// Reset (synchronous, active low) empties all queues, closes all banks with
// zero tokens and restores the configuration defaults; no clearing pass.
`default_nettype none
module dram_transaction_scheduler #(
    parameter int CHANNELS    = 4,
    parameter int QUEUE_DEPTH = 32,
    parameter int BANKS       = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire dts_pkg::t_in                     i_data,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output dts_pkg::t_out                         o_data,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [dts_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [dts_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int EIW = $clog2(QUEUE_DEPTH);
    localparam int FW  = $clog2(QUEUE_DEPTH + 1);
    localparam int CW  = (FW > 6) ? FW : 6;
    localparam int ED  = CHANNELS * 2 * (2 ** EIW);
    localparam int EAW = $clog2(ED);
    localparam int BIW = (BANKS > 1) ? $clog2(BANKS) : 1;
    localparam int EW  = $bits(dts_pkg::t_entry);
    localparam int BW  = $bits(dts_pkg::t_bank);

    typedef enum logic [4:0] {
        ST_IDLE, ST_P_START, ST_P_RD, ST_P_CHK, ST_P_WR,
        ST_S_START, ST_S_PICK, ST_S_NONE,
        ST_E_RD, ST_E_BANK, ST_E_TOK, ST_D_RD, ST_D_CHK, ST_E_END,
        ST_F_RD, ST_F_OUT, ST_M_RD, ST_M_WR, ST_DONE
    } t_state;

    t_state          r_state;
    dts_pkg::t_in    r_item;
    dts_pkg::t_out   r_res;
    dts_pkg::t_out   r_out;
    logic            r_out_vld;
    logic [CIW-1:0]  r_ch;

    logic            r_policy;
    logic            r_rfe;
    logic [5:0]      r_qlimit;
    logic [5:0]      r_whi;
    logic [5:0]      r_wlo;

    logic [FW-1:0]   r_fill0 [CHANNELS];
    logic [FW-1:0]   r_fill1 [CHANNELS];
    logic            r_drain [CHANNELS];
    logic            r_bk_valid [BANKS];

    logic            r_sel;
    logic            r_dsel;
    logic            r_other;
    logic [FW-1:0]   r_i;
    logic [FW-1:0]   r_k;
    logic [FW-1:0]   r_j;
    logic [FW-1:0]   r_first;
    logic            r_first_v;
    logic            r_elig;
    logic            r_hit;
    logic            r_bk_vld;
    dts_pkg::t_entry r_cand;

    // RAM ports
    logic            e_we;
    logic [EAW-1:0]  e_waddr;
    dts_pkg::t_entry e_wdata;
    logic [EAW-1:0]  e_raddr;
    dts_pkg::t_entry e_rdata;
    logic            b_we;
    logic [BIW-1:0]  b_waddr;
    dts_pkg::t_bank  b_wdata;
    logic [BIW-1:0]  b_raddr;
    dts_pkg::t_bank  b_rdata;

    logic [FW-1:0]   f0, f1, fsel, fdsel, fhit, fpush;
    logic            push_sel;
    logic [CW-1:0]   lim;
    logic            push_ok;
    logic [FW:0]     i_nxt, k_nxt, j_nxt, j_nxt2;
    logic [3:0]      tok;
    logic            in_accept;
    logic            in_ch_ok;
    logic            in_bank_ok;
    logic            cand_bank_ok;
    logic            drain_n;

    dts_ram #(.WIDTH(EW), .DEPTH(ED)) u_entries (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    dts_ram #(.WIDTH(BW), .DEPTH(BANKS)) u_banks (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    assign o_ready    = (r_state == ST_IDLE);
    assign o_valid    = r_out_vld;
    assign o_data     = r_out;
    assign in_accept  = i_valid && o_ready;
    assign in_ch_ok   = (32'(i_data.channel) < CHANNELS);
    assign in_bank_ok = (32'(i_data.bank) < BANKS);

    always_comb begin
        f0       = r_fill0[r_ch];
        f1       = r_fill1[r_ch];
        fsel     = r_sel ? f1 : f0;
        fdsel    = r_dsel ? f1 : f0;
        fhit     = r_rfe ? f1 : f0;
        push_sel = r_rfe && r_item.is_write;
        fpush    = push_sel ? f1 : f0;
        lim      = (CW'(r_qlimit) > CW'(QUEUE_DEPTH)) ? CW'(QUEUE_DEPTH) : CW'(r_qlimit);
        push_ok  = (CW'(fpush) < lim);
        i_nxt    = {1'b0, r_i} + 1'b1;
        k_nxt    = {1'b0, r_k} + 1'b1;
        j_nxt    = {1'b0, r_j} + 1'b1;
        j_nxt2   = {1'b0, r_j} + (FW+1)'(2);
        tok      = r_bk_vld ? b_rdata.tokens : 4'd0;
        cand_bank_ok = (32'(e_rdata.bank) < BANKS);
        if ((CW'(f1) >= CW'(r_whi)) || (f0 == '0)) begin
            drain_n = 1'b1;
        end else if (CW'(f1) < CW'(r_wlo)) begin
            drain_n = 1'b0;
        end else begin
            drain_n = r_drain[r_ch];
        end
    end

    // entry RAM access per state
    always_comb begin
        e_we    = 1'b0;
        e_waddr = EAW'({r_ch, r_sel, r_j[EIW-1:0]});
        e_wdata = e_rdata;
        e_raddr = EAW'({r_ch, r_sel, r_i[EIW-1:0]});
        unique case (r_state)
            ST_P_RD: e_raddr = EAW'({r_ch, r_rfe, r_k[EIW-1:0]});
            ST_D_RD: e_raddr = EAW'({r_ch, r_dsel, r_k[EIW-1:0]});
            ST_F_RD: e_raddr = EAW'({r_ch, r_sel, r_j[EIW-1:0]});
            ST_M_RD: e_raddr = EAW'({r_ch, r_sel, j_nxt[EIW-1:0]});
            ST_M_WR: e_we = 1'b1;
            ST_P_WR: begin
                e_we    = push_ok;
                e_waddr = EAW'({r_ch, push_sel, fpush[EIW-1:0]});
                e_wdata = '{address: r_item.address, is_write: r_item.is_write,
                            bank: r_item.bank, row: r_item.row, tag: r_item.txn_tag,
                            seq: r_item.seq_num};
            end
            default: ;
        endcase
    end

    always_comb begin
        b_we    = in_accept && (i_data.action == dts_pkg::ACT_BANK) && in_bank_ok;
        b_waddr = BIW'(i_data.bank);
        b_wdata = '{row_open: i_data.row_open, open_row: i_data.open_row,
                    tokens: i_data.tokens};
        b_raddr = BIW'(e_rdata.bank);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
            r_policy  <= 1'b0;
            r_rfe     <= 1'b0;
            r_qlimit  <= 6'd32;
            r_whi     <= 6'd32;
            r_wlo     <= 6'd6;
            for (int c = 0; c < CHANNELS; c++) begin
                r_fill0[c] <= '0;
                r_fill1[c] <= '0;
                r_drain[c] <= 1'b0;
            end
            for (int b = 0; b < BANKS; b++) begin
                r_bk_valid[b] <= 1'b0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    dts_pkg::CFG_POLICY:     r_policy <= i_cfg_data[0];
                    dts_pkg::CFG_READ_FIRST: r_rfe    <= i_cfg_data[0];
                    dts_pkg::CFG_LIMIT:      r_qlimit <= i_cfg_data;
                    dts_pkg::CFG_HIGH_MARK:  r_whi    <= i_cfg_data;
                    dts_pkg::CFG_LOW_MARK:   r_wlo    <= i_cfg_data;
                    default: ;
                endcase
            end
            // ST_DONE reloads the output register itself
            if (r_out_vld && i_ready && r_state != ST_DONE) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_item <= i_data;
                        r_res  <= '0;
                        r_ch   <= CIW'(i_data.channel);
                        if (b_we) begin
                            r_bk_valid[b_waddr] <= 1'b1;
                        end
                        if (i_data.action == dts_pkg::ACT_PUSH && in_ch_ok) begin
                            r_state <= ST_P_START;
                        end else if (i_data.action == dts_pkg::ACT_SCHED && in_ch_ok) begin
                            r_state <= ST_S_START;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_P_START: begin
                    r_k <= '0;
                    if (!r_item.is_write && fhit != '0) begin
                        r_state <= ST_P_RD;
                    end else begin
                        r_state <= ST_P_WR;
                    end
                end
                ST_P_RD: r_state <= ST_P_CHK;
                ST_P_CHK: begin
                    if (e_rdata.is_write && e_rdata.address == r_item.address) begin
                        r_res.write_hit <= 1'b1;
                    end
                    r_k <= k_nxt[FW-1:0];
                    r_state <= (k_nxt < {1'b0, fhit}) ? ST_P_RD : ST_P_WR;
                end
                ST_P_WR: begin
                    if (push_ok) begin
                        r_res.accepted <= 1'b1;
                        if (push_sel) begin
                            r_fill1[r_ch] <= f1 + 1'b1;
                        end else begin
                            r_fill0[r_ch] <= f0 + 1'b1;
                        end
                    end
                    r_state <= ST_DONE;
                end
                ST_S_START: begin
                    r_other <= 1'b0;
                    if (r_rfe) begin
                        r_drain[r_ch] <= drain_n;
                        r_sel <= drain_n;
                    end else begin
                        r_sel <= 1'b0;
                    end
                    r_state <= ST_S_PICK;
                end
                ST_S_PICK: begin
                    r_i       <= '0;
                    r_first_v <= 1'b0;
                    r_state   <= (fsel == '0) ? ST_S_NONE : ST_E_RD;
                end
                ST_S_NONE: begin
                    // nothing in this queue; read-first mode tries the other one
                    if (r_rfe && !r_other) begin
                        r_other <= 1'b1;
                        r_sel   <= ~r_sel;
                        r_state <= ST_S_PICK;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_E_RD: r_state <= ST_E_BANK;
                ST_E_BANK: begin
                    r_cand   <= e_rdata;
                    r_bk_vld <= cand_bank_ok && r_bk_valid[b_raddr];
                    r_state  <= ST_E_TOK;
                end
                ST_E_TOK: begin
                    r_hit  <= r_bk_vld && b_rdata.row_open && (b_rdata.open_row == r_cand.row);
                    r_dsel <= r_rfe && !r_cand.is_write;
                    r_k    <= '0;
                    if (32'(tok) < dts_pkg::TOKEN_NEED) begin
                        r_elig  <= 1'b0;
                        r_state <= ST_E_END;
                    end else begin
                        r_elig  <= 1'b1;
                        if (r_rfe && !r_cand.is_write) begin
                            r_state <= (f1 == '0) ? ST_E_END : ST_D_RD;
                        end else begin
                            r_state <= (f0 == '0) ? ST_E_END : ST_D_RD;
                        end
                    end
                end
                ST_D_RD: r_state <= ST_D_CHK;
                ST_D_CHK: begin
                    // scan stops at the first entry not older than the candidate
                    if (e_rdata.seq >= r_cand.seq) begin
                        r_state <= ST_E_END;
                    end else if (e_rdata.address == r_cand.address) begin
                        r_elig  <= 1'b0;
                        r_state <= ST_E_END;
                    end else begin
                        r_k     <= k_nxt[FW-1:0];
                        r_state <= (k_nxt < {1'b0, fdsel}) ? ST_D_RD : ST_E_END;
                    end
                end
                ST_E_END: begin
                    if (!r_policy) begin
                        r_j     <= '0;
                        r_state <= r_elig ? ST_F_RD : ST_S_NONE;
                    end else if (r_elig && r_hit) begin
                        r_j     <= r_i;
                        r_state <= ST_F_RD;
                    end else if (i_nxt < {1'b0, fsel}) begin
                        if (r_elig && !r_first_v) begin
                            r_first   <= r_i;
                            r_first_v <= 1'b1;
                        end
                        r_i     <= i_nxt[FW-1:0];
                        r_state <= ST_E_RD;
                    end else if (r_first_v) begin
                        r_j     <= r_first;
                        r_state <= ST_F_RD;
                    end else if (r_elig) begin
                        r_j     <= r_i;
                        r_state <= ST_F_RD;
                    end else begin
                        r_state <= ST_S_NONE;
                    end
                end
                ST_F_RD: r_state <= ST_F_OUT;
                ST_F_OUT: begin
                    r_res.issued          <= 1'b1;
                    r_res.issued_tag      <= e_rdata.tag;
                    r_res.issued_is_write <= e_rdata.is_write;
                    r_res.issued_address  <= e_rdata.address;
                    r_res.issued_bank     <= e_rdata.bank;
                    r_res.issued_row      <= e_rdata.row;
                    if (j_nxt < {1'b0, fsel}) begin
                        r_state <= ST_M_RD;
                    end else begin
                        if (r_sel) begin
                            r_fill1[r_ch] <= f1 - 1'b1;
                        end else begin
                            r_fill0[r_ch] <= f0 - 1'b1;
                        end
                        r_state <= ST_DONE;
                    end
                end
                ST_M_RD: r_state <= ST_M_WR;
                ST_M_WR: begin
                    // entry j+1 was read, now written down to j
                    r_j <= j_nxt[FW-1:0];
                    if (j_nxt2 < {1'b0, fsel}) begin
                        r_state <= ST_M_RD;
                    end else begin
                        if (r_sel) begin
                            r_fill1[r_ch] <= f1 - 1'b1;
                        end else begin
                            r_fill0[r_ch] <= f0 - 1'b1;
                        end
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_out_vld || i_ready) begin
                        r_out_vld <= 1'b1;
                        r_out     <= r_res;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for dram_transaction_scheduler: directed table, then random traffic.
// Depends on dts_pkg and the scheduler RTL; results are checked against an in-bench predictor or fixed expected values.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCH      = 4;
    localparam int DEPTH    = 32;
    localparam int NBANK    = 64;
    localparam int WDOG_MAX = 50000;
    localparam int IN_W     = $bits(dts_pkg::t_in);
    localparam int A_PUSH   = int'(dts_pkg::ACT_PUSH);
    localparam int A_SCHED  = int'(dts_pkg::ACT_SCHED);
    localparam int A_BANK   = int'(dts_pkg::ACT_BANK);
    localparam int A_UNUSED = int'(dts_pkg::ACT_UNUSED);

    typedef struct {
        dts_pkg::t_in  item;
        bit            typed;
        dts_pkg::t_out exp;
    } t_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_valid = 1'b0;
    logic                           o_ready;
    dts_pkg::t_in                   i_data = '0;
    logic                           o_valid;
    logic                           i_ready = 1'b0;
    dts_pkg::t_out                  o_data;
    logic                           i_cfg_wr_en = 1'b0;
    logic [dts_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [dts_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    dram_transaction_scheduler dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // scheduler state as the predictor sees it
    dts_pkg::t_entry q_ent [2*NCH][DEPTH];
    int              q_fill [2*NCH];
    dts_pkg::t_bank  banks [NBANK];
    bit              drain [NCH];
    bit              m_policy, m_rfirst;
    logic [5:0]      m_limit, m_high, m_low;

    dts_pkg::t_out   pending_results[$];
    t_row            plan[$];
    int              errors = 0;
    int              tx_idle = 0, rx_idle = 0;
    int              wdog = 0;

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
        errors++;
    endtask

    function automatic bit eligible(int q, int i, int ch);
        dts_pkg::t_entry e;
        int              dq;
        bit              dep;
        e = q_ent[q][i];
        dep = 0;
        if (32'(banks[e.bank].tokens) < dts_pkg::TOKEN_NEED) return 0;
        if (!m_rfirst) dq = 2*ch;
        else dq = e.is_write ? 2*ch : 2*ch + 1;
        for (int k = 0; k < q_fill[dq]; k++) begin
            if (q_ent[dq][k].address == e.address && q_ent[dq][k].seq < e.seq) dep = 1;
            if (q_ent[dq][k].seq >= e.seq) break;
        end
        return !dep;
    endfunction

    function automatic int pick_entry(int q, int ch);
        int              first;
        dts_pkg::t_entry e;
        first = -1;
        if (q_fill[q] == 0) return -1;
        if (!m_policy) return eligible(q, 0, ch) ? 0 : -1;
        for (int i = 0; i < q_fill[q]; i++) begin
            if (!eligible(q, i, ch)) continue;
            if (first < 0) first = i;
            e = q_ent[q][i];
            if (banks[e.bank].row_open && banks[e.bank].open_row == e.row) return i;
        end
        return first;
    endfunction

    function automatic dts_pkg::t_out sched_predict(dts_pkg::t_in it);
        dts_pkg::t_out   r;
        int              ch, q, hq, idx, lim;
        dts_pkg::t_entry e;
        r = '0;
        ch = int'(it.channel);
        lim = (int'(m_limit) > DEPTH) ? DEPTH : int'(m_limit);
        if (it.action == dts_pkg::ACT_PUSH) begin
            q = (m_rfirst && it.is_write) ? 2*ch + 1 : 2*ch;
            if (!it.is_write) begin
                hq = m_rfirst ? 2*ch + 1 : 2*ch;
                for (int k = 0; k < q_fill[hq]; k++)
                    if (q_ent[hq][k].is_write && q_ent[hq][k].address == it.address)
                        r.write_hit = 1'b1;
            end
            if (q_fill[q] < lim) begin
                e.address = it.address;  e.is_write = it.is_write;
                e.bank = it.bank;        e.row = it.row;
                e.tag = it.txn_tag;      e.seq = it.seq_num;
                q_ent[q][q_fill[q]] = e;
                q_fill[q]++;
                r.accepted = 1'b1;
            end
        end else if (it.action == dts_pkg::ACT_SCHED) begin
            q = 2*ch;
            if (m_rfirst) begin
                if (q_fill[2*ch+1] >= int'(m_high) || q_fill[2*ch] == 0) drain[ch] = 1;
                else if (q_fill[2*ch+1] < int'(m_low)) drain[ch] = 0;
                q = drain[ch] ? 2*ch + 1 : 2*ch;
            end
            idx = pick_entry(q, ch);
            if (idx < 0 && m_rfirst) begin
                q = (q == 2*ch) ? 2*ch + 1 : 2*ch;
                idx = pick_entry(q, ch);
            end
            if (idx >= 0) begin
                e = q_ent[q][idx];
                r.issued = 1'b1;           r.issued_tag = e.tag;
                r.issued_is_write = e.is_write;
                r.issued_address = e.address;
                r.issued_bank = e.bank;    r.issued_row = e.row;
                for (int k = idx; k < q_fill[q] - 1; k++) q_ent[q][k] = q_ent[q][k+1];
                q_fill[q]--;
            end
        end else if (it.action == dts_pkg::ACT_BANK) begin
            banks[it.bank].row_open = it.row_open;
            banks[it.bank].open_row = it.open_row;
            banks[it.bank].tokens   = it.tokens;
        end
        return r;
    endfunction

    // result side: receiver stalls, checking and the watchdog
    always @(posedge i_clk) begin
        dts_pkg::t_out want;
        i_ready <= ($urandom_range(0, 99) >= rx_idle);
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) wdog <= 0;
            else wdog <= wdog + 1;
            if (wdog >= WDOG_MAX) begin
                $display("FAIL");
                $finish;
            end
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", 32'd1, 32'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_data.accepted !== want.accepted)
                        report_mismatch("accepted", 32'(o_data.accepted),
                                        32'(want.accepted));
                    if (o_data.write_hit !== want.write_hit)
                        report_mismatch("write_hit", 32'(o_data.write_hit),
                                        32'(want.write_hit));
                    if (o_data.issued !== want.issued)
                        report_mismatch("issued", 32'(o_data.issued), 32'(want.issued));
                    if (o_data.issued_tag !== want.issued_tag)
                        report_mismatch("issued_tag", 32'(o_data.issued_tag),
                                        32'(want.issued_tag));
                    if (o_data.issued_is_write !== want.issued_is_write)
                        report_mismatch("issued_is_write", 32'(o_data.issued_is_write),
                                        32'(want.issued_is_write));
                    if (o_data.issued_address !== want.issued_address)
                        report_mismatch("issued_address", o_data.issued_address,
                                        want.issued_address);
                    if (o_data.issued_bank !== want.issued_bank)
                        report_mismatch("issued_bank", 32'(o_data.issued_bank),
                                        32'(want.issued_bank));
                    if (o_data.issued_row !== want.issued_row)
                        report_mismatch("issued_row", 32'(o_data.issued_row),
                                        32'(want.issued_row));
                end
            end
        end
    end

    // called at a rising edge; returns at the edge of the transfer
    task automatic drive_item(dts_pkg::t_in it, bit typed, dts_pkg::t_out typed_exp);
        dts_pkg::t_out r;
        if ($urandom_range(0, 99) < tx_idle) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < tx_idle);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        do @(posedge i_clk); while (!o_ready);
        r = sched_predict(it);
        pending_results.insert(pending_results.size(), typed ? typed_exp : r);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [dts_pkg::CFG_IDX_W-1:0] idx,
                             logic [dts_pkg::CFG_DATA_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            dts_pkg::CFG_POLICY:     m_policy = val[0];
            dts_pkg::CFG_READ_FIRST: m_rfirst = val[0];
            dts_pkg::CFG_LIMIT:      m_limit  = val;
            dts_pkg::CFG_HIGH_MARK:  m_high   = val;
            dts_pkg::CFG_LOW_MARK:   m_low    = val;
            default: ;
        endcase
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic dts_pkg::t_in mk(int act, int ch, int wr, int addr, int bk, int row,
                                        int seq, int tag, int ro, int orow, int tok);
        dts_pkg::t_in it;
        it.action = 2'(act);   it.channel = 2'(ch);    it.is_write = 1'(wr);
        it.address = 32'(addr);
        it.bank = 6'(bk);      it.row = 16'(row);      it.seq_num = 16'(seq);
        it.txn_tag = 8'(tag);  it.row_open = 1'(ro);   it.open_row = 16'(orow);
        it.tokens = 4'(tok);
        return it;
    endfunction

    task automatic add_row(dts_pkg::t_in it, bit typed, dts_pkg::t_out exp);
        t_row rw;
        rw.item  = it;
        rw.typed = typed;
        rw.exp   = exp;
        plan.insert(plan.size(), rw);
    endtask

    logic [15:0] seq_ctr = 16'd10;

    function automatic dts_pkg::t_in rand_item();
        dts_pkg::t_in it;
        int           sel;
        it = IN_W'({$urandom, $urandom, $urandom, $urandom});
        sel = $urandom_range(0, 99);
        if (sel < 42)      it.action = dts_pkg::ACT_PUSH;
        else if (sel < 78) it.action = dts_pkg::ACT_SCHED;
        else if (sel < 96) it.action = dts_pkg::ACT_BANK;
        else               it.action = dts_pkg::ACT_UNUSED;
        // small pools so addresses collide and rows hit
        if ($urandom_range(0, 9) < 8) it.address = {28'h0, 4'($urandom_range(0, 7))};
        if ($urandom_range(0, 9) < 8) it.bank = 6'($urandom_range(0, 7));
        if ($urandom_range(0, 9) < 7) it.row = 16'($urandom_range(0, 3));
        if ($urandom_range(0, 9) < 7) it.open_row = 16'($urandom_range(0, 3));
        if ($urandom_range(0, 9) < 7) it.tokens = 4'($urandom_range(3, 15));
        if ($urandom_range(0, 19) != 0) begin
            seq_ctr = seq_ctr + 16'($urandom_range(0, 2));
            it.seq_num = seq_ctr;
        end
        return it;
    endfunction

    initial begin
        dts_pkg::t_out zero_res, acc_res;
        logic [5:0]    settings [7][5];
        int            nrand;

        settings = '{'{0, 0, 32, 32, 6}, '{1, 0, 63, 32, 6}, '{1, 1, 4, 3, 1},
                     '{0, 1, 1, 0, 0},   '{1, 1, 32, 63, 63}, '{0, 1, 0, 5, 2},
                     '{1, 1, 8, 5, 2}};
        for (int q = 0; q < 2*NCH; q++) q_fill[q] = 0;
        for (int b = 0; b < NBANK; b++) banks[b] = '0;
        for (int c = 0; c < NCH; c++) drain[c] = 0;
        m_policy = 0; m_rfirst = 0; m_limit = 6'd32; m_high = 6'd32; m_low = 6'd6;

        zero_res = '0;
        acc_res = '0;
        acc_res.accepted = 1'b1;
        add_row(mk(A_SCHED, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, zero_res);
        add_row(mk(A_UNUSED, 3, 1, '1, '1, '1, '1, '1, 1, '1, '1), 1'b1, zero_res);
        add_row(mk(A_BANK, 0, 0, 0, 0, 0, 0, 0, 1, 16'h0, 15), 1'b1, zero_res);
        add_row(mk(A_BANK, 0, 0, 0, 63, 0, 0, 0, 1, 16'hffff, 3), 1'b1, zero_res);
        add_row(mk(A_BANK, 0, 0, 0, 1, 0, 0, 0, 0, 0, 2), 1'b1, zero_res);
        add_row(mk(A_PUSH, 0, 0, '1, 0, 0, 1, '1, 0, 0, 0), 1'b1, acc_res);
        add_row(mk(A_PUSH, 0, 1, '1, 63, '1, 2, 0, 0, 0, 0), 1'b1, acc_res);
        add_row(mk(A_PUSH, 0, 0, '1, 0, 5, 3, 8'h11, 0, 0, 0), 1'b0, zero_res);
        add_row(mk(A_PUSH, 3, 0, 32'h40, 1, 0, 4, 8'h22, 0, 0, 0), 1'b0, zero_res);
        add_row(mk(A_PUSH, 3, 1, 32'h41, 63, '1, '1, 8'h33, 0, 0, 0), 1'b0, zero_res);
        add_row(mk(A_SCHED, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, zero_res);
        add_row(mk(A_SCHED, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, zero_res);
        add_row(mk(A_SCHED, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, zero_res);
        add_row(mk(A_SCHED, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, zero_res);
        add_row(mk(A_SCHED, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, zero_res);
        add_row(mk(A_BANK, 0, 0, 0, 1, 0, 0, 0, 1, 0, 15), 1'b0, zero_res);
        add_row(mk(A_SCHED, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, zero_res);
        add_row(mk(A_SCHED, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, zero_res);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) drive_item(plan[i].item, plan[i].typed, plan[i].exp);

        for (int ph = 0; ph < 7; ph++) begin
            wait_idle();
            cfg_write(dts_pkg::CFG_POLICY,     settings[ph][0]);
            cfg_write(dts_pkg::CFG_READ_FIRST, settings[ph][1]);
            cfg_write(dts_pkg::CFG_LIMIT,      settings[ph][2]);
            cfg_write(dts_pkg::CFG_HIGH_MARK,  settings[ph][3]);
            cfg_write(dts_pkg::CFG_LOW_MARK,   settings[ph][4]);
            if (ph < 2)      begin tx_idle = 23; rx_idle = 55; end
            else if (ph < 4) begin tx_idle = 55; rx_idle = 23; end
            else             begin tx_idle = 0;  rx_idle = 0;  end
            nrand = (ph == 5) ? 30 : 128;
            for (int n = 0; n < nrand; n++) drive_item(rand_item(), 1'b0, zero_res);
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (50) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- dram_transaction_scheduler.f -----
rtl/dts_pkg.sv
rtl/dts_ram.sv
rtl/dram_transaction_scheduler.sv
test/testbench.sv
